// File: rtl/rz_pkg.sv
// Shared constants of the rolling z-score block.
package rz_pkg;

    localparam int DEF_MAX_WINDOW  = 64;
    localparam int DEF_SAMPLE_BITS = 24;

    localparam int IN_DATA_W  = 24;
    localparam int CFG_W      = 7;
    localparam int WIN_RESET  = 20;

    localparam int Z_W        = 20;
    localparam int ZQ_W       = Z_W + 1;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 2;
    localparam int FRAC_SHIFT = 32;

    localparam logic [ZQ_W-1:0] Z_MAX     = ZQ_W'(524287);
    localparam logic [ZQ_W-1:0] Z_MAG_NEG = ZQ_W'(524288);

endpackage

// File: rtl/rz_ram.sv
// Simple dual-port RAM with registered read, read-first on a same-address write.
module rz_ram #(
    parameter int WIDTH  = 24,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/rolling_zscore.sv
// Rolling z-score top level: ring, running sums, serial square root and divider.
// Each item runs read, old-sample and update; a warming item ends there, a flat item after the products and
// compare or the root, a full score after 46 root steps, a check, 63 divide steps and saturation.
// A new item is accepted only in ST_IDLE, after the last one has left ST_DONE; the shared
// compare-subtract unit serves both loops. A result waits in the output register while the next
// item runs; a finished item holds in ST_DONE until that register frees. Reset: window 20, sums,
// count and ring position cleared; ring contents left as they are. Config taken only when idle.
module rolling_zscore #(
    parameter int MAX_WINDOW  = rz_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = rz_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rz_pkg::IN_DATA_W-1:0]  s_tdata,   // [23:0] sample
    input  logic                          s_tuser,   // [0] restart
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rz_pkg::OUT_DATA_W-1:0] m_tdata,   // [19:0] zscore, [23:20] zero
    output logic [rz_pkg::OUT_USER_W-1:0] m_tuser,   // [0] warming, [1] flat
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rz_pkg::CFG_W-1:0]      cfg_data
);

    localparam int SB     = SAMPLE_BITS;
    localparam int IDX_W  = $clog2(MAX_WINDOW);
    localparam int WW     = rz_pkg::CFG_W;
    localparam int SUM_W  = SB + WW;
    localparam int SQ_W   = 2 * SB + 5;
    localparam int DEV_W  = 2 * SB + 12;
    localparam int RAD_W  = DEV_W + rz_pkg::FRAC_SHIFT;
    localparam int ROOT_W = RAD_W / 2;
    localparam int UW     = ROOT_W + 2;
    localparam int DIFF_W = SB + WW + 1;
    localparam int MAG_W  = SB + WW;
    localparam int NUM_W  = MAG_W + rz_pkg::FRAC_SHIFT;
    localparam int CNT_W  = $clog2(NUM_W + 1);
    localparam int ZQ_W   = rz_pkg::ZQ_W;
    localparam int Z_W    = rz_pkg::Z_W;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_READ = 4'd1;
    localparam logic [3:0] ST_OLD  = 4'd2;
    localparam logic [3:0] ST_UPD  = 4'd3;
    localparam logic [3:0] ST_MUL  = 4'd4;
    localparam logic [3:0] ST_CMP  = 4'd5;
    localparam logic [3:0] ST_SQRT = 4'd6;
    localparam logic [3:0] ST_CHK  = 4'd7;
    localparam logic [3:0] ST_DIV  = 4'd8;
    localparam logic [3:0] ST_SAT  = 4'd9;
    localparam logic [3:0] ST_DONE = 4'd10;

    logic [3:0]              state_reg;
    logic [WW-1:0]           wl_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic [WW-1:0]           seen_reg;
    logic [IDX_W-1:0]        wp_reg;

    logic signed [SB-1:0]     x_reg;
    logic signed [SB-1:0]     old_reg;
    logic                     drop_reg;
    logic [2*SB-1:0]          xsq_reg;
    logic [2*SB-1:0]          osq_reg;
    logic [DEV_W-1:0]         wq_reg;
    logic [DEV_W-1:0]         ss_reg;
    logic signed [DIFF_W-1:0] wx_reg;
    logic                     neg_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic [RAD_W-1:0]         rad_reg;
    logic [ROOT_W-1:0]        root_reg;
    logic [ROOT_W-1:0]        rem_reg;
    logic [ROOT_W-1:0]        drem_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [ZQ_W-1:0]          q_reg;
    logic                     ovf_reg;
    logic [CNT_W-1:0]         cnt_reg;

    logic [Z_W-1:0] res_z_reg;
    logic           res_warm_reg;
    logic           res_flat_reg;
    logic           m_valid_reg;
    logic [Z_W-1:0] m_z_reg;
    logic           m_warm_reg;
    logic           m_flat_reg;

    // window clamped to 1..MAX_WINDOW
    logic [WW-1:0] w_act;
    always_comb begin
        if (wl_reg == '0) begin
            w_act = WW'(1);
        end else if (32'(wl_reg) > MAX_WINDOW) begin
            w_act = WW'(MAX_WINDOW);
        end else begin
            w_act = wl_reg;
        end
    end

    // oldest sample position: wp - w modulo MAX_WINDOW
    logic [IDX_W:0]   rd_sum;
    logic [IDX_W-1:0] rd_idx;
    always_comb begin
        rd_sum = {1'b0, wp_reg} + (IDX_W+1)'(MAX_WINDOW) - (IDX_W+1)'(w_act);
        if (32'(rd_sum) >= MAX_WINDOW) begin
            rd_sum = rd_sum - (IDX_W+1)'(MAX_WINDOW);
        end
        rd_idx = rd_sum[IDX_W-1:0];
    end

    logic [SB-1:0] ram_rdata;

    rz_ram #(
        .WIDTH (SB),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .aclk  (aclk),
        .we    (state_reg == ST_READ),
        .waddr (wp_reg),
        .wdata (x_reg),
        .raddr (rd_idx),
        .rdata (ram_rdata)
    );

    // shared compare-subtract unit for root and divide steps
    logic [UW-1:0] u_a;
    logic [UW-1:0] u_b;
    logic [UW:0]   u_diff;
    logic          u_ge;
    always_comb begin
        if (state_reg == ST_SQRT) begin
            u_a = {rem_reg, rad_reg[RAD_W-1 -: 2]};
            u_b = {root_reg, 2'b01};
        end else begin
            u_a = UW'({drem_reg, num_reg[NUM_W-1]});
            u_b = UW'(root_reg);
        end
        u_diff = {1'b0, u_a} - {1'b0, u_b};
        u_ge   = !u_diff[UW];
    end

    // datapath helpers
    logic signed [SB-1:0]     x_in;
    logic [SB-1:0]            xmag;
    logic [SB-1:0]            omag;
    logic signed [SB-1:0]     old_s;
    logic [SUM_W-2:0]         smag;
    logic [WW-1:0]            seen_n;
    logic signed [SUM_W-1:0]  sum_n;
    logic [SQ_W-1:0]          sq_n;
    logic [DEV_W-1:0]         dev_c;
    logic signed [DIFF_W-1:0] diff_c;
    logic [ZQ_W-1:0]          lim;
    logic [ZQ_W-1:0]          qv;
    logic [ZQ_W-1:0]          qs;
    logic [IDX_W-1:0]         wp_n;

    always_comb begin
        x_in   = s_tdata[SB-1:0];
        xmag   = x_reg[SB-1] ? SB'(-x_reg) : SB'(x_reg);
        old_s  = ram_rdata;
        omag   = old_s[SB-1] ? SB'(-old_s) : SB'(old_s);
        smag   = sum_reg[SUM_W-1] ? (SUM_W-1)'(-sum_reg) : (SUM_W-1)'(sum_reg);
        seen_n = (seen_reg < w_act) ? seen_reg + WW'(1) : seen_reg;
        sum_n  = sum_reg + SUM_W'(x_reg) - (drop_reg ? SUM_W'(old_reg) : SUM_W'(0));
        sq_n   = sq_reg + SQ_W'(xsq_reg) - (drop_reg ? SQ_W'(osq_reg) : SQ_W'(0));
        dev_c  = wq_reg - ss_reg;
        diff_c = wx_reg - DIFF_W'(sum_reg);
        lim    = neg_reg ? rz_pkg::Z_MAG_NEG : rz_pkg::Z_MAX;
        qv     = (ovf_reg || q_reg > lim) ? lim : q_reg;
        qs     = neg_reg ? -qv : qv;
        wp_n   = (32'(wp_reg) == MAX_WINDOW - 1) ? '0 : wp_reg + IDX_W'(1);
    end

    // load the output register when a result is ready and the register frees this cycle
    logic out_load;
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wl_reg      <= WW'(rz_pkg::WIN_RESET);
            sum_reg     <= '0;
            sq_reg      <= '0;
            seen_reg    <= '0;
            wp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                wl_reg   <= cfg_data;
                sum_reg  <= '0;
                sq_reg   <= '0;
                seen_reg <= '0;
                wp_reg   <= '0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        x_reg     <= x_in;
                        state_reg <= ST_READ;
                        if (s_tuser) begin
                            sum_reg  <= '0;
                            sq_reg   <= '0;
                            seen_reg <= '0;
                            wp_reg   <= '0;
                        end
                    end
                end
                ST_READ: begin
                    drop_reg  <= (seen_reg >= w_act);
                    xsq_reg   <= xmag * xmag;
                    state_reg <= ST_OLD;
                end
                ST_OLD: begin
                    old_reg   <= old_s;
                    osq_reg   <= omag * omag;
                    state_reg <= ST_UPD;
                end
                ST_UPD: begin
                    sum_reg  <= sum_n;
                    sq_reg   <= sq_n;
                    seen_reg <= seen_n;
                    wp_reg   <= wp_n;
                    res_z_reg    <= '0;
                    res_warm_reg <= 1'b0;
                    res_flat_reg <= 1'b0;
                    if (seen_n < w_act) begin
                        res_warm_reg <= 1'b1;
                        state_reg    <= ST_DONE;
                    end else begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    wq_reg    <= DEV_W'(w_act) * DEV_W'(sq_reg);
                    ss_reg    <= DEV_W'(smag) * DEV_W'(smag);
                    wx_reg    <= DIFF_W'($signed({1'b0, w_act})) * DIFF_W'(x_reg);
                    state_reg <= ST_CMP;
                end
                ST_CMP: begin
                    neg_reg  <= diff_c[DIFF_W-1];
                    mag_reg  <= diff_c[DIFF_W-1] ? MAG_W'(-diff_c) : MAG_W'(diff_c);
                    rad_reg  <= {dev_c, {rz_pkg::FRAC_SHIFT{1'b0}}};
                    root_reg <= '0;
                    rem_reg  <= '0;
                    cnt_reg  <= CNT_W'(ROOT_W);
                    if (wq_reg <= ss_reg) begin
                        res_flat_reg <= 1'b1;
                        state_reg    <= ST_DONE;
                    end else begin
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    rem_reg   <= u_ge ? u_diff[ROOT_W-1:0] : u_a[ROOT_W-1:0];
                    root_reg  <= {root_reg[ROOT_W-2:0], u_ge};
                    rad_reg   <= {rad_reg[RAD_W-3:0], 2'b00};
                    cnt_reg   <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1)) begin
                        state_reg <= ST_CHK;
                    end
                end
                ST_CHK: begin
                    num_reg  <= {mag_reg, {rz_pkg::FRAC_SHIFT{1'b0}}};
                    drem_reg <= '0;
                    q_reg    <= '0;
                    ovf_reg  <= 1'b0;
                    cnt_reg  <= CNT_W'(NUM_W);
                    if (root_reg == '0) begin
                        res_flat_reg <= 1'b1;
                        state_reg    <= ST_DONE;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    drem_reg <= u_ge ? u_diff[ROOT_W-1:0] : u_a[ROOT_W-1:0];
                    q_reg    <= {q_reg[ZQ_W-2:0], u_ge};
                    ovf_reg  <= ovf_reg | q_reg[ZQ_W-1];
                    num_reg  <= {num_reg[NUM_W-2:0], 1'b0};
                    cnt_reg  <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1)) begin
                        state_reg <= ST_SAT;
                    end
                end
                ST_SAT: begin
                    res_z_reg <= qs[Z_W-1:0];
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    // hold until the output register is free
                    if (out_load) begin
                        m_z_reg     <= res_z_reg;
                        m_warm_reg  <= res_warm_reg;
                        m_flat_reg  <= res_flat_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // a config write takes priority over an input item while idle
    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_tready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(rz_pkg::OUT_DATA_W - Z_W){1'b0}}, m_z_reg};
    assign m_tuser   = {m_flat_reg, m_warm_reg};

endmodule

// File: bench/tb_rolling_zscore.sv
// Self-checking bench for the rolling z-score block: queued stimulus, bursty sender, stalling sink.
module tb_rolling_zscore;

    localparam int RING_DEPTH  = rz_pkg::DEF_MAX_WINDOW;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int HOLD_AT     = 250;
    localparam int HOLD_CYCLES = 800;
    localparam int DRAIN_WAIT  = 150;

    typedef struct {
        logic [rz_pkg::IN_DATA_W-1:0] sample;
        logic                         restart;
    } sample_item_t;

    typedef struct {
        logic [rz_pkg::Z_W-1:0] zscore;
        logic                   warming;
        logic                   flat;
    } zs_result_t;

    typedef enum int {
        SERIES_WIDE,
        SERIES_NEAR,
        SERIES_CONST,
        SERIES_EXTREME,
        SERIES_BITS
    } series_mode_e;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [rz_pkg::IN_DATA_W-1:0]  s_tdata   = '0;   // [23:0] sample
    logic                          s_tuser   = 1'b0; // [0] restart
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [rz_pkg::OUT_DATA_W-1:0] m_tdata;          // [19:0] zscore, [23:20] zero
    logic [rz_pkg::OUT_USER_W-1:0] m_tuser;          // [0] warming, [1] flat
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [rz_pkg::CFG_W-1:0]      cfg_data  = '0;

    // window state mirrored from the block
    longint                      win_hist [RING_DEPTH];
    longint                      win_sum;
    bit [63:0]                   win_sqsum;
    int unsigned                 win_count;
    int unsigned                 win_pos;
    logic [rz_pkg::CFG_W-1:0]    win_len;

    sample_item_t pending_samples[$];
    zs_result_t   expected_scores[$];
    sample_item_t next_sample;
    zs_result_t   want_score;

    int unsigned  accepted_items = 0;
    int unsigned  result_index   = 0;
    int unsigned  error_count    = 0;
    int unsigned  cycle_count    = 0;
    int unsigned  burst_left     = 1;
    int unsigned  gap_left       = 0;
    int unsigned  hold_left      = 0;
    bit           hold_done      = 1'b0;
    int unsigned  rx_tick        = 0;
    int unsigned  rx_period      = 1;
    int unsigned  rx_duty        = 1;

    rolling_zscore DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL rolling_zscore");
            $finish;
        end
    end

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("%s", msg);
    endtask

    function automatic bit [63:0] magnitude64(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic void clear_window();
        win_sum   = 0;
        win_sqsum = '0;
        win_count = 0;
        win_pos   = 0;
    endfunction

    // Advance the window by one sample and work out the score it yields.
    function automatic zs_result_t score_sample(input logic [rz_pkg::IN_DATA_W-1:0] raw,
                                                input logic restart);
        int unsigned w;
        int unsigned idx;
        longint      x;
        longint      oldest;
        longint      diff;
        bit [63:0]   mag;
        bit [63:0]   root;
        bit [63:0]   trial;
        bit [127:0]  wq;
        bit [127:0]  ss;
        bit [127:0]  scaled;
        bit [127:0]  num;
        bit [127:0]  quo;
        bit [127:0]  lim;
        zs_result_t  r;

        x = longint'($signed(raw));
        if (win_len == 0)
            w = 1;
        else if (win_len > RING_DEPTH)
            w = RING_DEPTH;
        else
            w = 32'(win_len);

        if (restart)
            clear_window();

        // drop the oldest sample once the window is full
        if (win_count >= w) begin
            idx = (win_pos + RING_DEPTH - w) % RING_DEPTH;
            oldest = win_hist[idx];
            mag = magnitude64(oldest);
            win_sum = win_sum - oldest;
            win_sqsum = win_sqsum - mag * mag;
        end
        mag = magnitude64(x);
        win_hist[win_pos] = x;
        win_sum = win_sum + x;
        win_sqsum = win_sqsum + mag * mag;
        win_pos = (win_pos + 1) % RING_DEPTH;
        if (win_count < w)
            win_count++;

        r.zscore  = '0;
        r.warming = 1'b0;
        r.flat    = 1'b0;
        if (win_count < w) begin
            r.warming = 1'b1;
            return r;
        end

        wq  = 128'(w) * 128'(win_sqsum);
        mag = magnitude64(win_sum);
        ss  = 128'(mag) * 128'(mag);
        if (wq <= ss) begin
            r.flat = 1'b1;
            return r;
        end
        scaled = (wq - ss) << 32;
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (128'(trial) * 128'(trial) <= scaled)
                root = trial;
        end
        if (root == 0) begin
            r.flat = 1'b1;
            return r;
        end

        diff = longint'(w) * x - win_sum;
        num  = 128'(magnitude64(diff)) << 32;
        quo  = num / 128'(root);
        lim  = (diff < 0) ? 128'(rz_pkg::Z_MAG_NEG) : 128'(rz_pkg::Z_MAX);
        if (quo > lim)
            quo = lim;
        r.zscore = (diff < 0) ? -quo[rz_pkg::Z_W-1:0] : quo[rz_pkg::Z_W-1:0];
        return r;
    endfunction

    // Sender: bursts of random length, random gaps, hold the item until taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_scores.insert(expected_scores.size(), score_sample(s_tdata, s_tuser));
                accepted_items <= accepted_items + 1;
            end
            if (s_tvalid && !s_tready) begin
                s_tvalid <= 1'b1;
            end else if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
                next_sample = pending_samples.pop_front();
                s_tdata  <= next_sample.sample;
                s_tuser  <= next_sample.restart;
                s_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    if ($urandom_range(0, 2) == 0)
                        gap_left <= 0;
                    else if ($urandom_range(0, 7) == 0)
                        gap_left <= $urandom_range(20, 200);
                    else
                        gap_left <= $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // One long sink hold-off, so the block fills up and stalls its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && accepted_items >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Sink: duty-cycle pattern that changes now and then; check every result taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_scores.size() == 0) begin
                    report_error($sformatf("result %0d arrived with none pending: zscore %0d",
                                           result_index, $signed(m_tdata[rz_pkg::Z_W-1:0])));
                end else begin
                    want_score = expected_scores.pop_front();
                    if (m_tdata[rz_pkg::Z_W-1:0] !== want_score.zscore ||
                        m_tuser[0] !== want_score.warming || m_tuser[1] !== want_score.flat)
                        report_error($sformatf(
                            "result %0d: zscore exp %0d got %0d, warming exp %0b got %0b, flat exp %0b got %0b",
                            result_index, $signed(want_score.zscore),
                            $signed(m_tdata[rz_pkg::Z_W-1:0]), want_score.warming,
                            m_tuser[0], want_score.flat, m_tuser[1]));
                end
                result_index <= result_index + 1;
            end
            if (rx_tick + 1 >= rx_period) begin
                rx_tick   <= 0;
                rx_period <= $urandom_range(1, 40);
                // full-rate stretches now and then
                rx_duty   <= ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 40);
            end else begin
                rx_tick <= rx_tick + 1;
            end
            m_tready <= (rx_tick < rx_duty) && (hold_left == 0);
        end
    end

    task automatic wait_idle();
        while (pending_samples.size() != 0 || s_tvalid || expected_scores.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_window(input logic [rz_pkg::CFG_W-1:0] len);
        wait_idle();
        cfg_data  <= len;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        win_len = len;
        clear_window();
    endtask

    task automatic add_sample(input logic [rz_pkg::IN_DATA_W-1:0] value, input logic restart);
        sample_item_t item;
        item.sample  = value;
        item.restart = restart;
        pending_samples.insert(pending_samples.size(), item);
    endtask

    // Queue runs of related samples; a few runs are broken up by restarts.
    task automatic queue_series(input int count);
        series_mode_e                 mode;
        int unsigned                  run_left;
        bit                           broken;
        logic [rz_pkg::IN_DATA_W-1:0] base;
        logic [rz_pkg::IN_DATA_W-1:0] value;
        logic                         restart;

        run_left = 0;
        mode     = SERIES_WIDE;
        broken   = 1'b0;
        base     = '0;
        for (int k = 0; k < count; k++) begin
            if (run_left == 0) begin
                mode     = series_mode_e'($urandom_range(0, 4));
                run_left = $urandom_range(4, 40);
                broken   = ($urandom_range(0, 9) == 0);
                base     = 24'($urandom());
            end
            run_left--;
            case (mode)
                SERIES_WIDE: begin
                    value = 24'($urandom());
                end
                SERIES_NEAR: begin
                    value = base + 24'($urandom_range(0, 30)) - 24'd15;
                end
                SERIES_CONST: begin
                    value = ($urandom_range(0, 15) == 0) ? 24'($urandom()) : base;
                end
                SERIES_EXTREME: begin
                    case ($urandom_range(0, 5))
                        0:       value = '0;
                        1:       value = '1;
                        2, 3:    value = 24'h7FFFFF;
                        default: value = 24'h800000;
                    endcase
                end
                default: begin
                    value = 24'd1 << $urandom_range(0, 23);
                    if ($urandom_range(0, 1) == 1)
                        value = ~value;
                end
            endcase
            restart = broken ? ($urandom_range(0, 5) == 0) : ($urandom_range(0, 299) == 0);
            add_sample(value, restart);
        end
    endtask

    task automatic run_phase(input logic [rz_pkg::CFG_W-1:0] len, input int count);
        set_window(len);
        queue_series(count);
    endtask

    initial begin
        win_len = 7'(rz_pkg::WIN_RESET);
        clear_window();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // short window: extremes, flat window, restart mid-series
        set_window(7'd3);
        add_sample(24'h7FFFFF, 1'b0);
        add_sample(24'h800000, 1'b0);
        add_sample(24'h000000, 1'b0);
        add_sample(24'h000000, 1'b0);
        add_sample(24'h000000, 1'b0);
        add_sample(24'h7FFFFF, 1'b0);
        add_sample(24'h800000, 1'b1);
        add_sample(24'h800000, 1'b0);
        add_sample(24'h800000, 1'b0);
        add_sample(24'h7FFFFF, 1'b0);
        add_sample(24'hFFFFFF, 1'b0);
        add_sample(24'h000001, 1'b0);
        add_sample(24'hFFFFFF, 1'b0);

        // zero length acts as a window of one: always flat
        set_window(7'd0);
        add_sample(24'h7FFFFF, 1'b0);
        add_sample(24'h800000, 1'b0);
        add_sample(24'h000000, 1'b1);
        add_sample(24'h000001, 1'b0);

        run_phase(7'd64, 160);
        run_phase(7'd127, 140);
        run_phase(7'd2, 100);
        run_phase(7'd20, 120);
        run_phase(7'd1, 60);
        run_phase(7'd65, 140);
        run_phase(7'd13, 100);
        run_phase(7'($urandom_range(1, 64)), 120);
        run_phase(7'd64, 140);

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (error_count == 0 && expected_scores.size() == 0)
            $display("PASS rolling_zscore");
        else
            $display("FAIL rolling_zscore");
        $finish;
    end

endmodule

// File: files.f
rtl/rz_pkg.sv
rtl/rz_ram.sv
rtl/rolling_zscore.sv
bench/tb_rolling_zscore.sv
